// ===== hdl/hcbp_pkg.sv =====
// shared types and constants for the huffman code bit packer
// holds the code table entry layout, the opcodes and the fsm state codes
// no dependencies
`default_nettype none

package hcbp_pkg;

  // code table geometry
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int WORD_BITS    = 32;
  localparam int BYTE_BITS    = 8;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int TABLE_DEPTH  = 256;

  // longest length an entry may store
  localparam int LEN_LIMIT = (MAX_CODE_LEN > WORD_BITS) ? WORD_BITS : MAX_CODE_LEN;

  // pending bits plus one code word, left aligned
  localparam int HELD_W = BYTE_BITS - 1;
  localparam int BUF_W  = HELD_W + WORD_BITS + 1;

  // input item kinds carried in tuser
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  // one code table entry
  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic [WORD_BITS-1:0] code;
  } entry_t;

  // control states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/huffman_code_bit_packer.sv =====
// huffman code bit packer: code table memory, bit accumulator and byte output register
// encode items read the 256-entry table, then emit completed bytes msb first
// depends on hcbp_pkg
// an encode reads its table entry, then emits bytes through the single byte output
// port, one per cycle while the output register is free; a flush emits pending bits
// as one byte. a new item is taken only in idle, once the item before is done.
// reset clears the pending bits, the pending bit count, the fsm and the output valid;
// the code table is not cleared and an entry reads as undefined until loaded
`default_nettype none

module huffman_code_bit_packer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  // input fields
  logic [hcbp_pkg::SYM_W-1:0]     in_symbol;
  logic [hcbp_pkg::WORD_BITS-1:0] in_code;
  logic [hcbp_pkg::LEN_W-1:0]     in_len;
  hcbp_pkg::op_t                  in_op;
  logic                           in_xfer;
  logic                           sym_ok;

  assign in_symbol = s_axis_tdata[7:0];
  assign in_code   = s_axis_tdata[39:8];
  assign in_len    = s_axis_tdata[45:40];
  assign in_op     = hcbp_pkg::op_t'(s_axis_tuser);
  assign sym_ok    = ({1'b0, in_symbol} < 9'(hcbp_pkg::SYMBOL_COUNT));

  // control and datapath registers
  hcbp_pkg::state_t              state;
  hcbp_pkg::entry_t              rd_entry;
  logic                          rd_ok;
  logic [hcbp_pkg::HELD_W-1:0]   pend;
  logic [2:0]                    held;
  logic [hcbp_pkg::BUF_W-1:0]    shift_buf;
  logic [2:0]                    byte_cnt;
  logic [2:0]                    rem;

  assign s_axis_tready = (state == hcbp_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // load entry: saturate the length and mask stray code bits
  logic [hcbp_pkg::LEN_W-1:0]     ld_len;
  logic [hcbp_pkg::WORD_BITS-1:0] ld_mask;
  hcbp_pkg::entry_t               ld_entry;

  always_comb begin
    if (in_len > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT)) begin
      ld_len = hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT);
    end else begin
      ld_len = in_len;
    end
    if (ld_len < hcbp_pkg::LEN_W'(hcbp_pkg::WORD_BITS)) begin
      ld_mask = ~({hcbp_pkg::WORD_BITS{1'b1}} << ld_len);
    end else begin
      ld_mask = {hcbp_pkg::WORD_BITS{1'b1}};
    end
    ld_entry.len  = ld_len;
    ld_entry.code = in_code & ld_mask;
  end

  // code table memory, one write and one registered read
  hcbp_pkg::entry_t code_mem [hcbp_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (in_xfer && in_op == hcbp_pkg::OP_LOAD && sym_ok) begin
      code_mem[in_symbol] <= ld_entry;
    end
    rd_entry <= code_mem[in_symbol];
  end

  // merge the code word behind the pending bits, left aligned
  logic [hcbp_pkg::LEN_W-1:0]     clen;
  logic [hcbp_pkg::WORD_BITS-1:0] code_left;
  logic [hcbp_pkg::BUF_W-1:0]     code_wide;
  logic [hcbp_pkg::BUF_W-1:0]     merged;
  logic [hcbp_pkg::LEN_W-1:0]     total;

  always_comb begin
    clen      = rd_entry.len;
    code_left = rd_entry.code << (hcbp_pkg::LEN_W'(hcbp_pkg::WORD_BITS) - clen);
    code_wide = {code_left, {(hcbp_pkg::BUF_W - hcbp_pkg::WORD_BITS){1'b0}}} >> held;
    merged    = {pend, {(hcbp_pkg::BUF_W - hcbp_pkg::HELD_W){1'b0}}} | code_wide;
    total     = {3'b000, held} + clen;
  end

  // output register free to take a byte this cycle
  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // a byte moves into the output register this cycle
  logic emit_now;
  assign emit_now = (state == hcbp_pkg::ST_EMIT) && out_free;

  // buffer after the top byte leaves
  logic [hcbp_pkg::BUF_W-1:0] buf_shifted;
  assign buf_shifted = shift_buf << hcbp_pkg::BYTE_BITS;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= hcbp_pkg::ST_IDLE;
      pend          <= '0;
      held          <= '0;
      m_axis_tvalid <= 1'b0;
      rd_ok         <= 1'b0;
      byte_cnt      <= '0;
      rem           <= '0;
    end else begin
      // output byte taken downstream with nothing new behind it
      if (m_axis_tvalid && m_axis_tready && !emit_now) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        hcbp_pkg::ST_IDLE: begin
          if (in_xfer) begin
            case (in_op)
              hcbp_pkg::OP_ENCODE: begin
                rd_ok <= sym_ok;
                state <= hcbp_pkg::ST_READ;
              end
              hcbp_pkg::OP_FLUSH: begin
                if (held != 3'd0) begin
                  shift_buf <= {pend, {(hcbp_pkg::BUF_W - hcbp_pkg::HELD_W){1'b0}}};
                  byte_cnt  <= 3'd1;
                  rem       <= 3'd0;
                  state     <= hcbp_pkg::ST_EMIT;
                end
              end
              default: begin
                state <= hcbp_pkg::ST_IDLE;
              end
            endcase
          end
        end

        hcbp_pkg::ST_READ: begin
          if (!rd_ok || clen == '0) begin
            state <= hcbp_pkg::ST_IDLE;
          end else if (total[5:3] == 3'd0) begin
            // still short of a byte
            pend  <= merged[hcbp_pkg::BUF_W-1 -: hcbp_pkg::HELD_W];
            held  <= total[2:0];
            state <= hcbp_pkg::ST_IDLE;
          end else begin
            shift_buf <= merged;
            byte_cnt  <= total[5:3];
            rem       <= total[2:0];
            state     <= hcbp_pkg::ST_EMIT;
          end
        end

        hcbp_pkg::ST_EMIT: begin
          // one byte per cycle into the output register while it is free
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= shift_buf[hcbp_pkg::BUF_W-1 -: hcbp_pkg::BYTE_BITS];
            m_axis_tlast  <= (byte_cnt == 3'd1);
            shift_buf     <= buf_shifted;
            byte_cnt      <= byte_cnt - 3'd1;
            if (byte_cnt == 3'd1) begin
              pend  <= buf_shifted[hcbp_pkg::BUF_W-1 -: hcbp_pkg::HELD_W];
              held  <= rem;
              state <= hcbp_pkg::ST_IDLE;
            end
          end
        end

        default: begin
          state <= hcbp_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
